// ===== sv/fsum_pkg.sv =====
// ----------------------------------------------------------------------------
// fsum_pkg: shared definitions for the floor sum block
// Constants of the prime field, state and opcode types, and the microcode
// that combines the per-level sums on the modular arithmetic unit.
// ----------------------------------------------------------------------------
package fsum_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int VALUE_BITS_DEF  = 32;
   localparam int FIELD_BITS      = 32;
   localparam int SUM_BITS        = 30;

   localparam logic [SUM_BITS-1:0] MODP     = 30'd998244353;
   localparam logic [SUM_BITS-1:0] MOD_INV2 = 30'd499122177;
   localparam logic [SUM_BITS-1:0] MOD_INV6 = 30'd166374059;

   // Scratch registers of the arithmetic unit.
   localparam int NUM_REGS = 16;
   localparam int PC_BITS  = 6;

   typedef enum logic [1:0] {
      KIND_REDUCE = 2'd0,
      KIND_SWAP   = 2'd1
   } kind_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [3:0]  dst;
      logic [4:0]  src_a;
      logic [4:0]  src_b;
      logic        last;
   } uop_type;

   typedef struct packed {
      logic               go;
      logic [PC_BITS-1:0] prog;
   } alu_cmd_type;

   typedef enum logic [3:0] {
      M_IDLE,
      M_LEVEL,
      M_DIVA,
      M_DIVB,
      M_PUSHR,
      M_MULN,
      M_DIVM,
      M_PUSHS,
      M_DIVBASE,
      M_RUN,
      M_POP,
      M_POPLD,
      M_DONE
   } main_state_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_RDA,
      A_RDB,
      A_LDB,
      A_MUL,
      A_WB
   } alu_state_type;

   // Program entry points.
   localparam logic [PC_BITS-1:0] PROG_CLEAR  = 6'd0;
   localparam logic [PC_BITS-1:0] PROG_BASE   = 6'd3;
   localparam logic [PC_BITS-1:0] PROG_REDUCE = 6'd11;
   localparam logic [PC_BITS-1:0] PROG_SWAP   = 6'd47;

   // Destinations: codes below DST_F are scratch registers.
   localparam logic [3:0] DST_F = 4'd12;
   localparam logic [3:0] DST_G = 4'd13;
   localparam logic [3:0] DST_H = 4'd14;

   // Sources: codes below SRC_F are scratch registers.
   localparam logic [4:0] SRC_F    = 5'd12;
   localparam logic [4:0] SRC_G    = 5'd13;
   localparam logic [4:0] SRC_H    = 5'd14;
   localparam logic [4:0] SRC_ONE  = 5'd16;
   localparam logic [4:0] SRC_INV2 = 5'd17;
   localparam logic [4:0] SRC_INV6 = 5'd18;
   localparam logic [4:0] SRC_ZERO = 5'd19;
   localparam logic [4:0] SRC_N    = 5'd20;
   localparam logic [4:0] SRC_N1   = 5'd21;
   localparam logic [4:0] SRC_QA   = 5'd22;
   localparam logic [4:0] SRC_QA1  = 5'd23;
   localparam logic [4:0] SRC_QB   = 5'd24;

   function automatic uop_type mk(alu_op_type op, logic [3:0] dst, logic [4:0] sa,
                                  logic [4:0] sb, logic last);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = sa;
      u.src_b = sb;
      u.last  = last;
      return u;
   endfunction

   // For OP_MUL the first operand is always a reduced value; the second may be
   // a raw count or quotient, which the product reduces on the way.
   function automatic uop_type uop_rom(logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         // Clear the level sums.
         6'd0:  u = mk(OP_ADD, DST_F, SRC_ZERO, SRC_ZERO, 1'b0);
         6'd1:  u = mk(OP_ADD, DST_G, SRC_ZERO, SRC_ZERO, 1'b0);
         6'd2:  u = mk(OP_ADD, DST_H, SRC_ZERO, SRC_ZERO, 1'b1);
         // Constant floor b/c over all indexes.
         6'd3:  u = mk(OP_MUL, 4'd0, SRC_ONE, SRC_QB, 1'b0);
         6'd4:  u = mk(OP_MUL, 4'd1, SRC_ONE, SRC_N1, 1'b0);
         6'd5:  u = mk(OP_MUL, DST_F, 5'd0, 5'd1, 1'b0);
         6'd6:  u = mk(OP_MUL, 4'd2, 5'd0, SRC_N, 1'b0);
         6'd7:  u = mk(OP_MUL, 4'd2, 5'd2, 5'd1, 1'b0);
         6'd8:  u = mk(OP_MUL, DST_G, 5'd2, SRC_INV2, 1'b0);
         6'd9:  u = mk(OP_MUL, 4'd2, 5'd0, 5'd0, 1'b0);
         6'd10: u = mk(OP_MUL, DST_H, 5'd2, 5'd1, 1'b1);
         // Reduce level: a and b were taken modulo c.
         6'd11: u = mk(OP_MUL, 4'd0, SRC_ONE, SRC_N, 1'b0);
         6'd12: u = mk(OP_MUL, 4'd1, SRC_ONE, SRC_N1, 1'b0);
         6'd13: u = mk(OP_ADD, 4'd2, 5'd0, 5'd0, 1'b0);
         6'd14: u = mk(OP_ADD, 4'd2, 5'd2, SRC_ONE, 1'b0);
         6'd15: u = mk(OP_MUL, 4'd3, SRC_ONE, SRC_QA, 1'b0);
         6'd16: u = mk(OP_MUL, 4'd4, SRC_ONE, SRC_QB, 1'b0);
         6'd17: u = mk(OP_MUL, 4'd5, 5'd0, 5'd1, 1'b0);
         6'd18: u = mk(OP_MUL, 4'd6, 5'd5, SRC_INV2, 1'b0);
         6'd19: u = mk(OP_MUL, 4'd7, 5'd5, 5'd2, 1'b0);
         6'd20: u = mk(OP_MUL, 4'd7, 5'd7, SRC_INV6, 1'b0);
         6'd21: u = mk(OP_MUL, 4'd8, 5'd6, 5'd3, 1'b0);
         6'd22: u = mk(OP_MUL, 4'd9, 5'd1, 5'd4, 1'b0);
         6'd23: u = mk(OP_ADD, 4'd8, 5'd8, 5'd9, 1'b0);
         6'd24: u = mk(OP_ADD, 4'd8, 5'd8, SRC_F, 1'b0);
         6'd25: u = mk(OP_MUL, 4'd9, 5'd7, 5'd3, 1'b0);
         6'd26: u = mk(OP_MUL, 4'd10, 5'd6, 5'd4, 1'b0);
         6'd27: u = mk(OP_ADD, 4'd9, 5'd9, 5'd10, 1'b0);
         6'd28: u = mk(OP_ADD, 4'd9, 5'd9, SRC_G, 1'b0);
         6'd29: u = mk(OP_MUL, 4'd10, 5'd3, 5'd3, 1'b0);
         6'd30: u = mk(OP_MUL, 4'd10, 5'd7, 5'd10, 1'b0);
         6'd31: u = mk(OP_MUL, 4'd11, 5'd4, 5'd4, 1'b0);
         6'd32: u = mk(OP_MUL, 4'd11, 5'd1, 5'd11, 1'b0);
         6'd33: u = mk(OP_ADD, 4'd10, 5'd10, 5'd11, 1'b0);
         6'd34: u = mk(OP_MUL, 4'd11, 5'd3, 5'd4, 1'b0);
         6'd35: u = mk(OP_MUL, 4'd11, 5'd11, 5'd6, 1'b0);
         6'd36: u = mk(OP_ADD, 4'd11, 5'd11, 5'd11, 1'b0);
         6'd37: u = mk(OP_ADD, 4'd10, 5'd10, 5'd11, 1'b0);
         6'd38: u = mk(OP_MUL, 4'd11, 5'd4, SRC_F, 1'b0);
         6'd39: u = mk(OP_ADD, 4'd11, 5'd11, 5'd11, 1'b0);
         6'd40: u = mk(OP_ADD, 4'd10, 5'd10, 5'd11, 1'b0);
         6'd41: u = mk(OP_MUL, 4'd11, 5'd3, SRC_G, 1'b0);
         6'd42: u = mk(OP_ADD, 4'd11, 5'd11, 5'd11, 1'b0);
         6'd43: u = mk(OP_ADD, 4'd10, 5'd10, 5'd11, 1'b0);
         6'd44: u = mk(OP_ADD, DST_H, 5'd10, SRC_H, 1'b0);
         6'd45: u = mk(OP_ADD, DST_F, 5'd8, SRC_ZERO, 1'b0);
         6'd46: u = mk(OP_ADD, DST_G, 5'd9, SRC_ZERO, 1'b1);
         // Swap level: the roles of a and c were exchanged.
         6'd47: u = mk(OP_MUL, 4'd0, SRC_ONE, SRC_N, 1'b0);
         6'd48: u = mk(OP_MUL, 4'd1, SRC_ONE, SRC_N1, 1'b0);
         6'd49: u = mk(OP_MUL, 4'd2, SRC_ONE, SRC_QA, 1'b0);
         6'd50: u = mk(OP_MUL, 4'd3, 5'd0, 5'd2, 1'b0);
         6'd51: u = mk(OP_SUB, 4'd4, 5'd3, SRC_F, 1'b0);
         6'd52: u = mk(OP_MUL, 4'd5, 5'd3, 5'd1, 1'b0);
         6'd53: u = mk(OP_SUB, 4'd5, 5'd5, SRC_H, 1'b0);
         6'd54: u = mk(OP_SUB, 4'd5, 5'd5, SRC_F, 1'b0);
         6'd55: u = mk(OP_MUL, 4'd5, 5'd5, SRC_INV2, 1'b0);
         6'd56: u = mk(OP_MUL, 4'd6, 5'd3, SRC_QA1, 1'b0);
         6'd57: u = mk(OP_ADD, 4'd7, SRC_G, SRC_G, 1'b0);
         6'd58: u = mk(OP_SUB, 4'd6, 5'd6, 5'd7, 1'b0);
         6'd59: u = mk(OP_ADD, 4'd7, SRC_F, SRC_F, 1'b0);
         6'd60: u = mk(OP_SUB, 4'd6, 5'd6, 5'd7, 1'b0);
         6'd61: u = mk(OP_SUB, DST_H, 5'd6, 5'd4, 1'b0);
         6'd62: u = mk(OP_ADD, DST_F, 5'd4, SRC_ZERO, 1'b0);
         6'd63: u = mk(OP_ADD, DST_G, 5'd5, SRC_ZERO, 1'b1);
         default: u = mk(OP_ADD, DST_F, SRC_ZERO, SRC_ZERO, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// ===== sv/fsum_ram.sv =====
// ----------------------------------------------------------------------------
// fsum_ram: generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fsum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fsum_alu.sv =====
// ----------------------------------------------------------------------------
// fsum_alu: microcoded modular arithmetic unit
// Runs a short program of add, subtract and bit-serial multiply modulo the
// prime over a small scratch RAM and the three running level sums.
// ----------------------------------------------------------------------------
module fsum_alu import fsum_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_cmd_type           cmd,
   input  logic [VALUE_BITS-1:0] lvl_n,
   input  logic [VALUE_BITS-1:0] lvl_qa,
   input  logic [VALUE_BITS-1:0] lvl_qb,
   output logic                  done,
   output logic [SUM_BITS-1:0]   sum_f,
   output logic [SUM_BITS-1:0]   sum_g,
   output logic [SUM_BITS-1:0]   sum_h
);

   // The second multiply operand carries raw counts up to 2^VALUE_BITS.
   localparam int OPW = (VALUE_BITS + 1 > SUM_BITS) ? VALUE_BITS + 1 : SUM_BITS;
   localparam int CNW = $clog2(OPW + 1);
   localparam int RAW = $clog2(NUM_REGS);

   alu_state_type        state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [SUM_BITS-1:0]  opa_ff, opa_in;
   logic [OPW-1:0]       opb_ff, opb_in;
   logic [SUM_BITS-1:0]  acc_ff, acc_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]  f_ff, f_in, g_ff, g_in, h_ff, h_in;

   uop_type              uop;
   logic [4:0]           sel;
   logic [OPW-1:0]       sel_val;
   logic [SUM_BITS-1:0]  rf_rdata;
   logic [RAW-1:0]       rf_raddr;
   logic                 rf_we;

   logic [SUM_BITS-1:0]  bv;
   logic [SUM_BITS:0]    add_sum;
   logic [SUM_BITS-1:0]  add_res;
   logic [SUM_BITS-1:0]  sub_res;
   logic [SUM_BITS:0]    dbl;
   logic [SUM_BITS-1:0]  dbl_r;
   logic [SUM_BITS:0]    acc_add;
   logic [SUM_BITS-1:0]  acc_add_r;
   logic [SUM_BITS-1:0]  mul_step;

   assign uop      = uop_rom(pc_ff);
   assign sel      = (state_ff == A_RDB) ? uop.src_a : uop.src_b;
   assign rf_raddr = (state_ff == A_RDA) ? uop.src_a[RAW-1:0] : uop.src_b[RAW-1:0];
   assign rf_we    = (state_ff == A_WB) && (uop.dst != DST_F) && (uop.dst != DST_G)
                     && (uop.dst != DST_H);

   fsum_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (uop.dst[RAW-1:0]),
      .wr_data (acc_ff),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   always_comb begin
      case (sel)
         SRC_F:    sel_val = OPW'(f_ff);
         SRC_G:    sel_val = OPW'(g_ff);
         SRC_H:    sel_val = OPW'(h_ff);
         SRC_ONE:  sel_val = OPW'(1);
         SRC_INV2: sel_val = OPW'(MOD_INV2);
         SRC_INV6: sel_val = OPW'(MOD_INV6);
         SRC_ZERO: sel_val = '0;
         SRC_N:    sel_val = OPW'(lvl_n);
         SRC_N1:   sel_val = OPW'(lvl_n) + OPW'(1);
         SRC_QA:   sel_val = OPW'(lvl_qa);
         SRC_QA1:  sel_val = OPW'(lvl_qa) + OPW'(1);
         SRC_QB:   sel_val = OPW'(lvl_qb);
         default:  sel_val = OPW'(rf_rdata);
      endcase
   end

   // Both operands of an add or subtract are already below the modulus.
   always_comb begin
      bv      = sel_val[SUM_BITS-1:0];
      add_sum = {1'b0, opa_ff} + {1'b0, bv};
      add_res = (add_sum >= {1'b0, MODP}) ? SUM_BITS'(add_sum - {1'b0, MODP})
                                          : add_sum[SUM_BITS-1:0];
      sub_res = (opa_ff >= bv) ? (opa_ff - bv) : SUM_BITS'({1'b0, opa_ff} + {1'b0, MODP}
                                                           - {1'b0, bv});
   end

   // One multiplier bit per cycle, most significant first: double, then add.
   always_comb begin
      dbl       = {acc_ff, 1'b0};
      dbl_r     = (dbl >= {1'b0, MODP}) ? SUM_BITS'(dbl - {1'b0, MODP})
                                        : dbl[SUM_BITS-1:0];
      acc_add   = {1'b0, dbl_r} + {1'b0, opa_ff};
      acc_add_r = (acc_add >= {1'b0, MODP}) ? SUM_BITS'(acc_add - {1'b0, MODP})
                                            : acc_add[SUM_BITS-1:0];
      mul_step  = opb_ff[OPW-1] ? acc_add_r : dbl_r;
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      f_in     = f_ff;
      g_in     = g_ff;
      h_in     = h_ff;
      done     = 1'b0;
      case (state_ff)
         A_IDLE: begin
            if (cmd.go) begin
               pc_in    = cmd.prog;
               state_in = A_RDA;
            end
         end
         A_RDA: begin
            state_in = A_RDB;
         end
         A_RDB: begin
            opa_in   = sel_val[SUM_BITS-1:0];
            state_in = A_LDB;
         end
         A_LDB: begin
            opb_in = sel_val;
            case (uop.op)
               OP_MUL: begin
                  acc_in   = '0;
                  cnt_in   = CNW'(OPW);
                  state_in = A_MUL;
               end
               OP_SUB: begin
                  acc_in   = sub_res;
                  state_in = A_WB;
               end
               default: begin
                  acc_in   = add_res;
                  state_in = A_WB;
               end
            endcase
         end
         A_MUL: begin
            acc_in = mul_step;
            opb_in = {opb_ff[OPW-2:0], 1'b0};
            cnt_in = cnt_ff - CNW'(1);
            if (cnt_ff == CNW'(1)) begin
               state_in = A_WB;
            end
         end
         A_WB: begin
            case (uop.dst)
               DST_F:   f_in = acc_ff;
               DST_G:   g_in = acc_ff;
               DST_H:   h_in = acc_ff;
               default: f_in = f_ff;
            endcase
            if (uop.last) begin
               done     = 1'b1;
               state_in = A_IDLE;
            end else begin
               pc_in    = pc_ff + PC_BITS'(1);
               state_in = A_RDA;
            end
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff  <= pc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      f_ff   <= f_in;
      g_ff   <= g_in;
      h_ff   <= h_in;
   end

   assign sum_f = f_ff;
   assign sum_g = g_ff;
   assign sum_h = h_ff;

endmodule

// ===== sv/floor_sum_mod.sv =====
// ----------------------------------------------------------------------------
// floor_sum_mod: floor sums modulo 998244353
// Like-Euclidean reduction with a level stack and bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage: drive req_count_n, req_slope_a, req_offset_b and req_divisor_c and
// raise start while busy is low; the item is taken at that clock edge and
// busy stays high until the result has been shown. The result is on the rsp_
// ports for exactly one cycle, marked by rsp_valid, and busy falls in the
// following cycle. The receiver cannot hold a result off.
// Latency depends on the data. The descent divides bit-serially for each
// quotient of a reduce level and multiplies, then divides, bit-serially for the
// product and quotient of a swap level. The ascent runs on one bit-serial
// modular multiplier. One item is in work at a time.
// Reset returns the sequencer to idle; the level stack needs no clearing.
// ----------------------------------------------------------------------------
module floor_sum_mod import fsum_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] req_count_n,
   input  logic [FIELD_BITS-1:0] req_slope_a,
   input  logic [FIELD_BITS-1:0] req_offset_b,
   input  logic [FIELD_BITS-1:0] req_divisor_c,
   output logic                  rsp_valid,
   output logic [SUM_BITS-1:0]   rsp_sum_floor,
   output logic [SUM_BITS-1:0]   rsp_sum_index_floor,
   output logic [SUM_BITS-1:0]   rsp_sum_floor_squared
);

   localparam int W   = VALUE_BITS;
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SW  = 2 + 3 * W;
   localparam int CW  = $clog2(2 * W + 1);

   main_state_type state_ff, state_in;
   logic [W-1:0]   a_ff, a_in, b_ff, b_in, c_ff, c_in, n_ff, n_in;
   logic [SPW-1:0] sp_ff, sp_in, sp_dec;
   logic [2*W-1:0] num_ff, num_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]   lvl_n_ff, lvl_n_in, lvl_qa_ff, lvl_qa_in, lvl_qb_ff, lvl_qb_in;
   alu_cmd_type    cmd_ff, cmd_in;

   logic [W:0]     trial;
   logic           trial_ge;
   logic [W-1:0]   rem_step;
   logic [2*W-1:0] num_div;
   logic [W:0]     psum;
   logic [2*W-1:0] num_mul;
   logic           last_step;
   logic           stack_full;

   logic           stk_we;
   logic [SW-1:0]  stk_wdata;
   logic [SW-1:0]  stk_rdata;
   kind_type       pop_kind;

   logic           alu_done;
   logic [SUM_BITS-1:0] sum_f, sum_g, sum_h;

   // Restoring division, one quotient bit per cycle into the low end.
   assign trial    = {rem_ff, num_ff[2*W-1]};
   assign trial_ge = trial >= {1'b0, c_ff};
   assign rem_step = trial_ge ? W'(trial - {1'b0, c_ff}) : trial[W-1:0];
   assign num_div  = {num_ff[2*W-2:0], trial_ge};

   // Shift-add product of a and n, one multiplier bit per cycle.
   assign psum    = {1'b0, num_ff[2*W-1:W]} + (num_ff[0] ? {1'b0, a_ff} : '0);
   assign num_mul = {psum, num_ff[W-1:1]};

   assign last_step  = cnt_ff == CW'(1);
   assign stack_full = sp_ff == SPW'(STACK_DEPTH);
   assign sp_dec     = sp_ff - SPW'(1);
   assign pop_kind   = kind_type'(stk_rdata[SW-1:3*W]);

   fsum_ram #(
      .WIDTH (SW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (stk_wdata),
      .rd_addr (sp_dec[AW-1:0]),
      .rd_data (stk_rdata)
   );

   fsum_alu #(
      .VALUE_BITS (VALUE_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .lvl_n  (lvl_n_ff),
      .lvl_qa (lvl_qa_ff),
      .lvl_qb (lvl_qb_ff),
      .done   (alu_done),
      .sum_f  (sum_f),
      .sum_g  (sum_g),
      .sum_h  (sum_h)
   );

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      sp_in     = sp_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      lvl_n_in  = lvl_n_ff;
      lvl_qa_in = lvl_qa_ff;
      lvl_qb_in = lvl_qb_ff;
      cmd_in    = cmd_ff;
      cmd_in.go = 1'b0;
      stk_we    = 1'b0;
      stk_wdata = {KIND_REDUCE, lvl_qa_ff, lvl_qb_ff, n_ff};
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               n_in     = req_count_n[W-1:0];
               a_in     = req_slope_a[W-1:0];
               b_in     = req_offset_b[W-1:0];
               c_in     = req_divisor_c[W-1:0];
               sp_in    = '0;
               state_in = M_LEVEL;
            end
         end
         M_LEVEL: begin
            rem_in = '0;
            cnt_in = CW'(W);
            if (c_ff == '0) begin
               cmd_in   = '{go: 1'b1, prog: PROG_CLEAR};
               state_in = M_RUN;
            end else if (a_ff == '0) begin
               num_in   = {b_ff, {W{1'b0}}};
               state_in = M_DIVBASE;
            end else if (stack_full) begin
               cmd_in   = '{go: 1'b1, prog: PROG_CLEAR};
               state_in = M_RUN;
            end else if ((a_ff >= c_ff) || (b_ff >= c_ff)) begin
               num_in   = {a_ff, {W{1'b0}}};
               state_in = M_DIVA;
            end else begin
               num_in   = {{W{1'b0}}, n_ff};
               state_in = M_MULN;
            end
         end
         M_DIVA: begin
            num_in = num_div;
            rem_in = rem_step;
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               lvl_qa_in = num_div[W-1:0];
               a_in      = rem_step;
               num_in    = {b_ff, {W{1'b0}}};
               rem_in    = '0;
               cnt_in    = CW'(W);
               state_in  = M_DIVB;
            end
         end
         M_DIVB: begin
            num_in = num_div;
            rem_in = rem_step;
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               lvl_qb_in = num_div[W-1:0];
               b_in      = rem_step;
               state_in  = M_PUSHR;
            end
         end
         M_PUSHR: begin
            stk_we    = 1'b1;
            stk_wdata = {KIND_REDUCE, lvl_qa_ff, lvl_qb_ff, n_ff};
            sp_in     = sp_ff + SPW'(1);
            state_in  = M_LEVEL;
         end
         M_MULN: begin
            num_in = num_mul;
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               num_in   = num_mul + {{W{1'b0}}, b_ff};
               rem_in   = '0;
               cnt_in   = CW'(2 * W);
               state_in = M_DIVM;
            end
         end
         M_DIVM: begin
            num_in = num_div;
            rem_in = rem_step;
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               // An empty swap level leaves nothing below it.
               if (num_div[W-1:0] == '0) begin
                  cmd_in   = '{go: 1'b1, prog: PROG_CLEAR};
                  state_in = M_RUN;
               end else begin
                  lvl_qa_in = num_div[W-1:0];
                  state_in  = M_PUSHS;
               end
            end
         end
         M_PUSHS: begin
            stk_we    = 1'b1;
            stk_wdata = {KIND_SWAP, lvl_qa_ff, {W{1'b0}}, n_ff};
            sp_in     = sp_ff + SPW'(1);
            a_in      = c_ff;
            b_in      = c_ff - b_ff - W'(1);
            c_in      = a_ff;
            n_in      = lvl_qa_ff - W'(1);
            state_in  = M_LEVEL;
         end
         M_DIVBASE: begin
            num_in = num_div;
            rem_in = rem_step;
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               lvl_qb_in = num_div[W-1:0];
               lvl_n_in  = n_ff;
               cmd_in    = '{go: 1'b1, prog: PROG_BASE};
               state_in  = M_RUN;
            end
         end
         M_RUN: begin
            if (alu_done) begin
               state_in = M_POP;
            end
         end
         M_POP: begin
            if (sp_ff == '0) begin
               state_in = M_DONE;
            end else begin
               sp_in    = sp_dec;
               state_in = M_POPLD;
            end
         end
         M_POPLD: begin
            lvl_n_in  = stk_rdata[W-1:0];
            lvl_qb_in = stk_rdata[2*W-1:W];
            lvl_qa_in = stk_rdata[3*W-1:2*W];
            if (pop_kind == KIND_SWAP) begin
               cmd_in = '{go: 1'b1, prog: PROG_SWAP};
            end else begin
               cmd_in = '{go: 1'b1, prog: PROG_REDUCE};
            end
            state_in = M_RUN;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         sp_ff    <= '0;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      n_ff        <= n_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      lvl_n_ff    <= lvl_n_in;
      lvl_qa_ff   <= lvl_qa_in;
      lvl_qb_ff   <= lvl_qb_in;
   end

   assign busy                  = state_ff != M_IDLE;
   assign rsp_valid             = state_ff == M_DONE;
   assign rsp_sum_floor         = sum_f;
   assign rsp_sum_index_floor   = sum_g;
   assign rsp_sum_floor_squared = sum_h;

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sum_floor < MODP) && (rsp_sum_index_floor < MODP)
                    && (rsp_sum_floor_squared < MODP))
      else $error("result sum not reduced below the modulus");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == M_RUN)
      else $error("arithmetic program finished outside the run state");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_we |-> sp_ff < SPW'(STACK_DEPTH))
      else $error("level pushed onto a full stack");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for floor_sum_mod
// Sends items of (n, a, b, c) in random bursts, predicts the three floor
// sums modulo the prime in software and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
   import fsum_pkg::*;

   localparam longint unsigned PRIME       = 64'd998244353;
   localparam longint unsigned HALF_INV    = 64'd499122177;
   localparam longint unsigned SIXTH_INV   = 64'd166374059;
   localparam int              LEVELS      = STACK_DEPTH_DEF;
   localparam longint          CYCLE_LIMIT = 64'd50_000_000;
   localparam int              PAUSE_AT    = 40;

   typedef struct {
      logic [31:0] n;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } item_type;

   typedef struct {
      logic [SUM_BITS-1:0] f;
      logic [SUM_BITS-1:0] g;
      logic [SUM_BITS-1:0] h;
   } sums_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [31:0] req_count_n = '0;
   logic [31:0] req_slope_a = '0;
   logic [31:0] req_offset_b = '0;
   logic [31:0] req_divisor_c = '0;
   logic busy;
   logic rsp_valid;
   logic [SUM_BITS-1:0] rsp_sum_floor;
   logic [SUM_BITS-1:0] rsp_sum_index_floor;
   logic [SUM_BITS-1:0] rsp_sum_floor_squared;

   item_type pending_items[$];
   sums_type expected_sums[$];
   item_type shown_item;
   int mismatches = 0;
   int items_sent = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit paused_once = 1'b0;
   longint cycles = 0;

   floor_sum_mod uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_count_n(req_count_n), .req_slope_a(req_slope_a),
      .req_offset_b(req_offset_b), .req_divisor_c(req_divisor_c),
      .rsp_valid(rsp_valid), .rsp_sum_floor(rsp_sum_floor),
      .rsp_sum_index_floor(rsp_sum_index_floor),
      .rsp_sum_floor_squared(rsp_sum_floor_squared)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned mulm(longint unsigned x, longint unsigned y);
      return ((x % PRIME) * (y % PRIME)) % PRIME;
   endfunction

   function automatic longint unsigned subm(longint unsigned x, longint unsigned y);
      return ((x % PRIME) + PRIME - (y % PRIME)) % PRIME;
   endfunction

   function automatic sums_type floor_sums(item_type it);
      longint unsigned n, a, b, c, m, t, nm, n1, n21, qa, qb, s1, s2, f0, g0, h0;
      longint unsigned f, g, h;
      longint unsigned lv_qa[LEVELS];
      longint unsigned lv_qb[LEVELS];
      longint unsigned lv_n[LEVELS];
      kind_type lv_kind[LEVELS];
      int depth;
      bit done;
      sums_type r;
      n = it.n; a = it.a; b = it.b; c = it.c;
      f = 0; g = 0; h = 0;
      depth = 0;
      done = (c == 0);
      while (!done) begin
         if (a == 0) begin
            qb = (b / c) % PRIME;
            n1 = (n + 1) % PRIME;
            f = mulm(qb, n1);
            g = mulm(mulm(mulm(qb, n), n1), HALF_INV);
            h = mulm(mulm(qb, qb), n1);
            done = 1'b1;
         end else if (depth >= LEVELS) begin
            done = 1'b1;
         end else if (a >= c || b >= c) begin
            lv_kind[depth] = KIND_REDUCE;
            lv_qa[depth] = a / c;
            lv_qb[depth] = b / c;
            lv_n[depth] = n;
            depth++;
            a = a % c;
            b = b % c;
         end else begin
            m = (a * n + b) / c;
            if (m == 0) begin
               done = 1'b1;
            end else begin
               lv_kind[depth] = KIND_SWAP;
               lv_qa[depth] = m;
               lv_qb[depth] = 0;
               lv_n[depth] = n;
               depth++;
               t = c;
               b = c - b - 1;
               c = a;
               a = t;
               n = m - 1;
            end
         end
      end
      // Combine the levels from the innermost outward.
      while (depth > 0) begin
         depth--;
         nm = lv_n[depth] % PRIME;
         n1 = (lv_n[depth] + 1) % PRIME;
         f0 = f; g0 = g; h0 = h;
         if (lv_kind[depth] == KIND_REDUCE) begin
            n21 = (2 * nm + 1) % PRIME;
            qa = lv_qa[depth] % PRIME;
            qb = lv_qb[depth] % PRIME;
            s1 = mulm(mulm(nm, n1), HALF_INV);
            s2 = mulm(mulm(mulm(nm, n1), n21), SIXTH_INV);
            f = (mulm(s1, qa) + mulm(n1, qb) + f0) % PRIME;
            g = (mulm(s2, qa) + mulm(s1, qb) + g0) % PRIME;
            h = mulm(s2, mulm(qa, qa));
            h = (h + mulm(n1, mulm(qb, qb))) % PRIME;
            h = (h + mulm(2, mulm(mulm(qa, qb), s1))) % PRIME;
            h = (h + mulm(2, mulm(qb, f0))) % PRIME;
            h = (h + mulm(2, mulm(qa, g0))) % PRIME;
            h = (h + h0) % PRIME;
         end else begin
            m = lv_qa[depth];
            f = subm(mulm(nm, m), f0);
            g = mulm(subm(subm(mulm(mulm(m % PRIME, nm), n1), h0), f0), HALF_INV);
            h = mulm(mulm(nm, m), (m + 1) % PRIME);
            h = subm(h, mulm(2, g0));
            h = subm(h, mulm(2, f0));
            h = subm(h, f);
         end
      end
      r.f = f[SUM_BITS-1:0];
      r.g = g[SUM_BITS-1:0];
      r.h = h[SUM_BITS-1:0];
      return r;
   endfunction

   task automatic add_item(logic [31:0] n, logic [31:0] a, logic [31:0] b, logic [31:0] c);
      item_type it;
      it.n = n; it.a = a; it.b = b; it.c = c;
      pending_items.push_back(it);
   endtask

   function automatic logic [31:0] rand_bits(int bits);
      logic [31:0] v;
      v = $urandom;
      if (bits < 32) v = v & ((32'd1 << bits) - 1);
      return v;
   endfunction

   // Driver: an item is taken when start is high and busy is low.
   always @(posedge clock) begin
      bit taken;
      bit present;
      item_type it;
      cycles <= cycles + 1;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_sums.push_back(floor_sums(shown_item));
            items_sent++;
         end
         present = start && !taken;
         if (!present && pending_items.size() > 0) begin
            if (items_sent == PAUSE_AT && !paused_once) begin
               // Hold off until the block has drained every result.
               if (expected_sums.size() == 0 && !busy) paused_once = 1'b1;
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               it = pending_items.pop_front();
               shown_item = it;
               req_count_n <= it.n;
               req_slope_a <= it.a;
               req_offset_b <= it.b;
               req_divisor_c <= it.c;
               present = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         start <= present;
      end
   end

   // Monitor: each result is valid for one cycle only.
   always @(posedge clock) begin
      sums_type want;
      if (!reset && rsp_valid) begin
         if (expected_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %0d %0d %0d",
               rsp_sum_floor, rsp_sum_index_floor, rsp_sum_floor_squared);
         end else begin
            want = expected_sums.pop_front();
            if (want.f !== rsp_sum_floor || want.g !== rsp_sum_index_floor ||
                want.h !== rsp_sum_floor_squared) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.f, want.g, want.h, rsp_sum_floor, rsp_sum_index_floor,
                     rsp_sum_floor_squared);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int bits;
      // Extremes and the named special cases.
      add_item(32'd0, 32'd0, 32'd0, 32'd1);
      add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
      add_item(32'hFFFFFFFF, 32'd1, 32'd0, 32'hFFFFFFFF);
      add_item(32'd10, 32'd3, 32'd5, 32'd0);
      add_item(32'd1000, 32'd0, 32'd77, 32'd5);
      add_item(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd1);
      add_item(32'd5, 32'd1, 32'd0, 32'd100);
      add_item(32'd100, 32'd7, 32'd3, 32'd10);
      add_item(32'd1000000, 32'd3, 32'd2, 32'd5);
      add_item(32'hFFFFFFFF, 32'h9E3779B9, 32'h12345678, 32'hF0000001);
      add_item(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd7);
      add_item(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
      add_item(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAB);
      add_item(32'd2971215072, 32'd1836311903, 32'd0, 32'd2971215073);
      for (int k = 0; k < 135; k++) begin
         bits = (k % 15 == 7) ? 32 : $urandom_range(1, 16);
         add_item(rand_bits(bits), rand_bits(bits), rand_bits(bits),
                  rand_bits(bits) | 32'd1);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !start && expected_sums.size() == 0 && !busy);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_sums.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fsum_pkg.sv
sv/fsum_ram.sv
sv/fsum_alu.sv
sv/floor_sum_mod.sv
verif/testbench.sv
